// ===== rtl/button_click_classifier_core_macros.svh =====
// Assertion macros for the button click classifier.
// Expects clk and rst_n in the scope of use.
`ifndef BUTTON_CLICK_CLASSIFIER_CORE_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define BCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define BCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bcc_pkg.sv =====
// Shared types and constants for the button click classifier.
// No dependencies.
`default_nettype none

package bcc_pkg;

    localparam int TIME_BITS    = 32;
    localparam int EVENT_BITS   = 32;
    localparam int THR_BITS     = 16;
    localparam int REQ_BITS     = 2;
    localparam int KIND_BITS    = 2;
    localparam int CFG_IDX_BITS = 2;

    typedef logic [TIME_BITS-1:0]  time_t;
    typedef logic [EVENT_BITS-1:0] event_time_t;
    typedef logic [THR_BITS-1:0]   thr_t;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_PRESS   = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_CLEAR   = 2'd2
    } req_t;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_NONE   = 2'd0,
        KIND_SINGLE = 2'd1,
        KIND_DOUBLE = 2'd2,
        KIND_HOLD   = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SINGLE_MAX = 2'd0,
        CFG_DOUBLE_MAX = 2'd1,
        CFG_HOLD_MIN   = 2'd2
    } cfg_idx_t;

    localparam thr_t SINGLE_MAX_RST = 16'd300;
    localparam thr_t DOUBLE_MAX_RST = 16'd500;
    localparam thr_t HOLD_MIN_RST   = 16'd1000;

    typedef struct packed {
        thr_t single_max;
        thr_t double_max;
        thr_t hold_min;
    } cfg_t;

    // One event handed from the input stage to the classifier.
    typedef struct packed {
        logic                step;
        logic [REQ_BITS-1:0] req_type;
        time_t               ev_time;
    } step_t;

endpackage

`default_nettype wire

// ===== rtl/bcc_if.sv =====
// Valid/ready channel interfaces for the button click classifier.
// Depends on bcc_pkg.
`default_nettype none

interface bcc_req_if;
    import bcc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [REQ_BITS-1:0]       req_type;
    logic [EVENT_BITS-1:0]     event_time;

    modport source (output valid, output req_type, output event_time, input ready);
    modport sink   (input valid, input req_type, input event_time, output ready);
endinterface

interface bcc_rsp_if;
    import bcc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [KIND_BITS-1:0]  click_kind;

    modport source (output valid, output click_kind, input ready);
    modport sink   (input valid, input click_kind, output ready);
endinterface

`default_nettype wire

// ===== rtl/bcc_cfg_regs.sv =====
// Threshold registers of the button click classifier, plain write port.
// Depends on bcc_pkg.
`default_nettype none

module bcc_cfg_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [bcc_pkg::CFG_IDX_BITS-1:0] cfg_idx,
    input  wire logic [bcc_pkg::THR_BITS-1:0] cfg_wdata,
    output bcc_pkg::cfg_t                     cfg
);
    import bcc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_idx))
                CFG_SINGLE_MAX: cfg_next.single_max = cfg_wdata;
                CFG_DOUBLE_MAX: cfg_next.double_max = cfg_wdata;
                CFG_HOLD_MIN:   cfg_next.hold_min   = cfg_wdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.single_max <= SINGLE_MAX_RST;
            cfg_reg.double_max <= DOUBLE_MAX_RST;
            cfg_reg.hold_min   <= HOLD_MIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/bcc_classify.sv =====
// Click state and classification logic: one event per step.
// Depends on bcc_pkg and the assertion macro header.
`default_nettype none
`include "button_click_classifier_core_macros.svh"

module bcc_classify (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bcc_pkg::cfg_t                 cfg,
    input  wire bcc_pkg::step_t                ev,
    output logic [bcc_pkg::KIND_BITS-1:0]      kind_next
);
    import bcc_pkg::*;

    logic  pending_reg, pending_next;
    time_t press_start_reg, press_start_next;
    time_t press_end_reg, press_end_next;
    time_t prior_start_reg, prior_start_next;
    kind_t last_kind_reg, last_kind_next;

    time_t len;
    time_t gap;
    logic  single_ok, hold_ok, double_ok;
    logic  is_release;

    // Differences against the new end time; negative or unset prior gives 0.
    always_comb
    begin
        len = (ev.ev_time >= press_start_reg) ? ev.ev_time - press_start_reg : '0;
        gap = (prior_start_reg != '0 && ev.ev_time >= prior_start_reg)
              ? ev.ev_time - prior_start_reg : '0;
        single_ok  = len <= time_t'(cfg.single_max);
        hold_ok    = len >= time_t'(cfg.hold_min);
        double_ok  = gap <= time_t'(cfg.double_max);
        is_release = ev.step && (req_t'(ev.req_type) == REQ_RELEASE);
    end

    always_comb
    begin
        pending_next     = pending_reg;
        press_start_next = press_start_reg;
        press_end_next   = press_end_reg;
        prior_start_next = prior_start_reg;
        last_kind_next   = last_kind_reg;
        if (ev.step)
        begin
            unique case (req_t'(ev.req_type))
                REQ_PRESS:
                begin
                    if (pending_reg)
                    begin
                        prior_start_next = press_start_reg;
                        press_end_next   = '0;
                    end
                    press_start_next = ev.ev_time;
                end
                REQ_RELEASE:
                begin
                    press_end_next = ev.ev_time;
                    if (!pending_reg)
                    begin
                        if (single_ok)
                        begin
                            last_kind_next = KIND_SINGLE;
                            pending_next   = 1'b1;
                        end
                        else if (hold_ok)
                        begin
                            last_kind_next   = KIND_HOLD;
                            press_start_next = '0;
                            press_end_next   = '0;
                            prior_start_next = '0;
                        end
                    end
                    else
                    begin
                        if (double_ok)
                        begin
                            last_kind_next   = KIND_DOUBLE;
                            pending_next     = 1'b0;
                            press_start_next = '0;
                            press_end_next   = '0;
                            prior_start_next = '0;
                        end
                        else if (single_ok)
                        begin
                            last_kind_next = KIND_SINGLE;
                        end
                    end
                end
                REQ_CLEAR:
                begin
                    pending_next     = 1'b0;
                    press_start_next = '0;
                    press_end_next   = '0;
                    prior_start_next = '0;
                    last_kind_next   = KIND_NONE;
                end
                default: ; // unused code: state kept
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg     <= 1'b0;
            press_start_reg <= '0;
            press_end_reg   <= '0;
            prior_start_reg <= '0;
            last_kind_reg   <= KIND_NONE;
        end
        else
        begin
            pending_reg     <= pending_next;
            press_start_reg <= press_start_next;
            press_end_reg   <= press_end_next;
            prior_start_reg <= prior_start_next;
            last_kind_reg   <= last_kind_next;
        end
    end

    assign kind_next = last_kind_next;

    `BCC_ASSERT_NEXT(a_clear_resets,
        ev.step && req_t'(ev.req_type) == REQ_CLEAR,
        !pending_reg && last_kind_reg == KIND_NONE && press_start_reg == '0,
        "clear did not reset state")
    `BCC_ASSERT_NEXT(a_double_clears,
        is_release && pending_reg && double_ok,
        !pending_reg && press_start_reg == '0 && prior_start_reg == '0
            && last_kind_reg == KIND_DOUBLE,
        "double click left state behind")
    `BCC_ASSERT_NEXT(a_hold_clears,
        is_release && !pending_reg && !single_ok && hold_ok,
        !pending_reg && press_end_reg == '0 && last_kind_reg == KIND_HOLD,
        "hold left state behind")

endmodule

`default_nettype wire

// ===== rtl/button_click_classifier_core.sv =====
// Top level of the button click classifier: input register, classifier, result register.
// Depends on bcc_pkg, bcc_if, bcc_cfg_regs, bcc_classify and the macro header.
//
//   channel  dir  payload                   handshake
//   req      in   req_type, event_time      valid/ready
//   rsp      out  click_kind                valid/ready
//   cfg      in   cfg_idx, cfg_wdata        cfg_we, no stall
//
// Each event passes from acceptance into the input register, then through the
// classifier into the result register; the classifier state is registered with it.
// One event is accepted per cycle unless a stalled result holds a full input register.
// A stalled result holds the input register, which then drops req.ready.
// Reset clears the valid flags, the click state and loads threshold defaults.
`default_nettype none
`include "button_click_classifier_core_macros.svh"

module button_click_classifier_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    bcc_req_if.sink                               req,
    bcc_rsp_if.source                             rsp,
    input  wire logic                             cfg_we,
    input  wire logic [bcc_pkg::CFG_IDX_BITS-1:0] cfg_idx,
    input  wire logic [bcc_pkg::THR_BITS-1:0]     cfg_wdata
);
    import bcc_pkg::*;

    cfg_t                 cfg;
    step_t                ev;
    logic [KIND_BITS-1:0] kind_next;

    logic                 in_valid_reg, in_valid_next;
    logic [REQ_BITS-1:0]  in_req_reg;
    time_t                in_time_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [KIND_BITS-1:0] out_kind_reg;
    logic                 advance;
    logic                 accept;

    assign advance   = !out_valid_reg || rsp.ready;
    assign req.ready = !in_valid_reg || advance;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = in_valid_reg;
            in_valid_next  = 1'b0;
        end
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_req_reg  <= req.req_type;
            in_time_reg <= time_t'(req.event_time);
        end
        if (ev.step)
        begin
            out_kind_reg <= kind_next;
        end
    end

    assign ev.step     = in_valid_reg && advance;
    assign ev.req_type = in_req_reg;
    assign ev.ev_time  = in_time_reg;

    bcc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bcc_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .ev        (ev),
        .kind_next (kind_next)
    );

    assign rsp.valid      = out_valid_reg;
    assign rsp.click_kind = out_kind_reg;

    `BCC_ASSERT_NEXT(a_in_held, in_valid_reg && !advance, in_valid_reg && $stable(in_req_reg), "stalled input item lost")

endmodule

`default_nettype wire
